@@ src/lbs_pkg.sv @@
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared widths, codes and defaults for the session-affinity balancer.
// ----------------------------------------------------------------------------
package lbs_pkg;

  localparam int SESSION_ENTRIES_DEF = 1024;
  localparam int BACKEND_ENTRIES_DEF = 256;

  localparam int MAC_W = 48;
  localparam int KEY_W = 96;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'h06;
  localparam logic [15:0] MIN_FRAME      = 16'd54;

  // Result action codes
  localparam logic [1:0] ACT_PASS     = 2'd0;
  localparam logic [1:0] ACT_REDIRECT = 2'd1;
  localparam logic [1:0] ACT_WRITTEN  = 2'd2;

  // Input command codes
  localparam logic CMD_FRAME   = 1'b0;
  localparam logic CMD_BACKEND = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_LISTEN_PORT   = 2'd0;
  localparam logic [1:0] CFG_BACKEND_COUNT = 2'd1;
  localparam logic [1:0] CFG_OUT_INTERFACE = 2'd2;

endpackage

@@ src/lbs_ram.sv @@
// ----------------------------------------------------------------------------
// lbs_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/lbs_mod.sv @@
// ----------------------------------------------------------------------------
// lbs_mod
// Bit-serial restoring remainder of the 8-bit counter by the backend count.
// A divisor of zero leaves the dividend, as the modulo rule requires.
// ----------------------------------------------------------------------------
module lbs_mod (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [7:0]  dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [7:0]  remainder
);

  logic [16:0] rem;
  logic [7:0]  quo;
  logic [3:0]  cnt;
  logic        busy;
  logic [16:0] shifted;

  // One dividend bit per step
  assign shifted = {rem[15:0], quo[7]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 4'd8;
      rem  <= '0;
      quo  <= dividend;
    end else if (busy) begin
      quo <= {quo[6:0], 1'b0};
      if (shifted >= {1'b0, divisor}) begin
        rem <= shifted - {1'b0, divisor};
      end else begin
        rem <= shifted;
      end
      cnt <= cnt - 4'd1;
      if (cnt == 4'd1) begin
        busy <= 1'b0;
      end
    end
  end

  assign done      = !busy;
  assign remainder = rem[7:0];

endmodule

@@ src/tcp_session_affinity_balancer_top.sv @@
// ----------------------------------------------------------------------------
// tcp_session_affinity_balancer_top
// Round-robin load balancer with sticky TCP sessions and exact LRU.
// ----------------------------------------------------------------------------
// Pass and table-write items go from S_IDLE straight to S_FINISH, which
// registers the result and raises out_valid once the output is not stalled.
// Forwarded frames pass S_SEARCH, S_DECIDE, S_BREAD on a miss and S_UPDATE:
// one sweep of the session RAM searches, a second ages the LRU ranks (none when
// the backend index is out of range); one item is processed at a time.
// Reset clears the configuration registers, counter, fill count and backend valid bits.
module tcp_session_affinity_balancer_top #(
  parameter int SESSION_ENTRIES = lbs_pkg::SESSION_ENTRIES_DEF,
  parameter int BACKEND_ENTRIES = lbs_pkg::BACKEND_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [15:0] frame_length,
  input  logic [15:0] ether_type,
  input  logic [7:0]  ip_protocol,
  input  logic [31:0] source_ip,
  input  logic [31:0] dest_ip,
  input  logic [15:0] source_port,
  input  logic [15:0] dest_port,
  input  logic [47:0] frame_dest_mac,
  input  logic [7:0]  write_index,
  input  logic [47:0] write_mac,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  action,
  output logic [47:0] new_source_mac,
  output logic [47:0] new_dest_mac,
  output logic [15:0] redirect_interface,
  output logic        session_hit,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import lbs_pkg::*;

  localparam int SIW = $clog2(SESSION_ENTRIES);
  localparam int BIW = $clog2(BACKEND_ENTRIES);
  localparam int KW  = KEY_W + MAC_W;
  localparam logic [SIW:0] FULL_COUNT = (SIW+1)'(SESSION_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_DECIDE, S_BREAD, S_UPDATE, S_FINISH
  } state_t;

  state_t state;

  // Configuration registers
  logic [15:0] balanced_port, backend_count, out_interface;

  // Item registers
  logic [KEY_W-1:0] key;
  logic [MAC_W-1:0] fdmac, mac;
  logic [7:0]       rr_counter;
  logic [SIW:0]     used, ptr;
  logic             rv;
  logic [SIW-1:0]   ra, slot, limit, hit_slot, hit_rec, lru_slot, lru_rec;
  logic [MAC_W-1:0] hit_mac;
  logic             hit, age_all;
  logic [1:0]       res_action;

  logic [BACKEND_ENTRIES-1:0] bvalid;
  logic                       bvq;

  // Memory ports
  logic           s_re;
  logic [KW-1:0]  k_rdata;
  logic [SIW-1:0] r_rdata, r_wdata;
  logic           r_we, k_we;
  logic           b_we, b_re;
  logic [MAC_W-1:0] b_rdata;

  logic       accept, forward, full;
  logic       mod_done;
  logic [7:0] mod_rem;
  logic       idx_bad, widx_ok;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign full      = (used == FULL_COUNT);
  assign forward   = (frame_length >= MIN_FRAME) && (ether_type == ETHERTYPE_IPV4) &&
                     (ip_protocol == PROTO_TCP) && (dest_port == balanced_port);
  assign widx_ok   = ({1'b0, write_index} < 9'(BACKEND_ENTRIES));
  assign idx_bad   = ({1'b0, mod_rem} >= 9'(BACKEND_ENTRIES));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      balanced_port <= '0;
      backend_count <= '0;
      out_interface <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LISTEN_PORT:   balanced_port <= cfg_data;
        CFG_BACKEND_COUNT: backend_count <= cfg_data;
        CFG_OUT_INTERFACE: out_interface <= cfg_data;
        default: ;
      endcase
    end
  end

  // Round-robin index
  lbs_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && command == CMD_FRAME),
    .dividend (rr_counter),
    .divisor  (backend_count),
    .done     (mod_done),
    .remainder(mod_rem)
  );

  // Backend table with per-entry valid bits
  assign b_we = accept && command == CMD_BACKEND && widx_ok;
  assign b_re = (state == S_DECIDE) && mod_done && !hit && !idx_bad;

  lbs_ram #(.WIDTH(MAC_W), .DEPTH(BACKEND_ENTRIES)) u_backend (
    .clk  (clk),
    .we   (b_we),
    .waddr(write_index[BIW-1:0]),
    .wdata(write_mac),
    .re   (b_re),
    .raddr(mod_rem[BIW-1:0]),
    .rdata(b_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid <= '0;
    end else if (b_we) begin
      bvalid[write_index[BIW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (b_re) begin
      bvq <= bvalid[mod_rem[BIW-1:0]];
    end
  end

  // Session key/MAC store and LRU rank store
  assign s_re = (state == S_SEARCH || state == S_UPDATE) && (ptr < used);
  assign r_we = (state == S_UPDATE) && rv;
  assign k_we = r_we && (ra == slot) && !hit;

  // Age ranks younger than the limit (all ranks on a miss), make the touched entry most recent
  always_comb begin
    if (ra == slot) begin
      r_wdata = '0;
    end else if (age_all || r_rdata < limit) begin
      r_wdata = r_rdata + SIW'(1);
    end else begin
      r_wdata = r_rdata;
    end
  end

  lbs_ram #(.WIDTH(KW), .DEPTH(SESSION_ENTRIES)) u_keys (
    .clk  (clk),
    .we   (k_we),
    .waddr(slot),
    .wdata({key, mac}),
    .re   (s_re),
    .raddr(ptr[SIW-1:0]),
    .rdata(k_rdata)
  );

  lbs_ram #(.WIDTH(SIW), .DEPTH(SESSION_ENTRIES)) u_ranks (
    .clk  (clk),
    .we   (r_we),
    .waddr(ra),
    .wdata(r_wdata),
    .re   (s_re),
    .raddr(ptr[SIW-1:0]),
    .rdata(r_rdata)
  );

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      rr_counter <= '0;
      used       <= '0;
      rv         <= 1'b0;
    end else begin
      // Drop a taken result unless a new one loads in this cycle
      if (out_valid && !out_stall && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            key      <= {source_ip, dest_ip, source_port, dest_port};
            fdmac    <= frame_dest_mac;
            ptr      <= '0;
            rv       <= 1'b0;
            hit      <= 1'b0;
            lru_rec  <= '0;
            lru_slot <= '0;
            if (command == CMD_BACKEND) begin
              res_action <= ACT_WRITTEN;
              state      <= S_FINISH;
            end else if (!forward) begin
              res_action <= ACT_PASS;
              state      <= S_FINISH;
            end else begin
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (s_re) begin
            ptr <= ptr + (SIW+1)'(1);
          end
          rv <= s_re;
          ra <= ptr[SIW-1:0];
          if (rv) begin
            if (!hit && k_rdata[KW-1 -: KEY_W] == key) begin
              hit      <= 1'b1;
              hit_slot <= ra;
              hit_rec  <= r_rdata;
              hit_mac  <= k_rdata[MAC_W-1:0];
            end
            if (r_rdata >= lru_rec) begin
              lru_rec  <= r_rdata;
              lru_slot <= ra;
            end
          end
          if (!s_re && !rv) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          ptr <= '0;
          rv  <= 1'b0;
          if (hit) begin
            slot    <= hit_slot;
            limit   <= hit_rec;
            age_all <= 1'b0;
            mac     <= hit_mac;
            state   <= S_UPDATE;
          end else if (mod_done) begin
            if (idx_bad) begin
              res_action <= ACT_PASS;
              state      <= S_FINISH;
            end else begin
              slot       <= full ? lru_slot : used[SIW-1:0];
              used       <= full ? used : used + (SIW+1)'(1);
              age_all    <= 1'b1;
              limit      <= '0;
              rr_counter <= rr_counter + 8'd1;
              state      <= S_BREAD;
            end
          end
        end
        S_BREAD: begin
          mac   <= bvq ? b_rdata : '0;
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (s_re) begin
            ptr <= ptr + (SIW+1)'(1);
          end
          rv <= s_re;
          ra <= ptr[SIW-1:0];
          if (!s_re && !rv) begin
            res_action <= ACT_REDIRECT;
            state      <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            action    <= res_action;
            if (res_action == ACT_REDIRECT) begin
              new_source_mac     <= fdmac;
              new_dest_mac       <= mac;
              redirect_interface <= out_interface;
              session_hit        <= hit;
            end else begin
              new_source_mac     <= '0;
              new_dest_mac       <= '0;
              redirect_interface <= '0;
              session_hit        <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
